[src/client_session_table_with_aging_defines.svh]
// ----------------------------------------------------------------------------
// Client session table assertion macros
// Shared concurrent assertion forms for the session table RTL.
// ----------------------------------------------------------------------------
`ifndef CLIENT_SESSION_TABLE_WITH_AGING_DEFINES_SVH
`define CLIENT_SESSION_TABLE_WITH_AGING_DEFINES_SVH

// Condition holds at every edge out of reset.
`define CSTA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define CSTA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CSTA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/csta_pkg.sv]
// ----------------------------------------------------------------------------
// Client session table package
// Field widths, register map, result codes and the table entry layout.
// ----------------------------------------------------------------------------
package csta_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 64;

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned PORT_W = 16;
	localparam int unsigned ID_W   = 6;
	localparam int unsigned TICK_W = 32;
	localparam int unsigned SLOT_W = 6;
	localparam int unsigned LIVE_W = 7;
	localparam int unsigned STAT_W = 3;
	localparam int unsigned TMO_W  = 16;

	// APB register map
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_IDLE_TIMEOUT = '0;

	localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 16'd300;
	localparam logic [TICK_W-1:0] TICK_RESET    = 32'd1;

	typedef enum logic [STAT_W-1:0] {
		ST_HIT        = 3'd0,
		ST_NEW        = 3'd1,
		ST_FULL       = 3'd2,
		ST_TIMED_OUT  = 3'd3,
		ST_SWEEP_NONE = 3'd4
	} status_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [PORT_W-1:0] port;
		logic [ID_W-1:0]   id;
		logic [TICK_W-1:0] seen_tick;
		logic [TICK_W-1:0] client_tick;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

[src/csta_if.sv]
// ----------------------------------------------------------------------------
// Client session table channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface csta_req_if;
	logic                             valid;
	logic                             ready;
	logic                             req_type;
	logic [csta_pkg::ADDR_W-1:0]      source_address;
	logic [csta_pkg::PORT_W-1:0]      source_port;
	logic signed [csta_pkg::TICK_W-1:0] client_tick;

	modport source (output valid, req_type, source_address, source_port, client_tick,
		input ready);
	modport sink (input valid, req_type, source_address, source_port, client_tick,
		output ready);
endinterface

interface csta_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [csta_pkg::STAT_W-1:0] status;
	logic [csta_pkg::SLOT_W-1:0] slot_index;
	logic [csta_pkg::ID_W-1:0]   client_id;
	logic [csta_pkg::LIVE_W-1:0] live_count;
	logic [csta_pkg::TICK_W-1:0] server_tick;
	logic                        last_of_run;

	modport source (output valid, status, slot_index, client_id, live_count, server_tick,
		last_of_run, input ready);
	modport sink (input valid, status, slot_index, client_id, live_count, server_tick,
		last_of_run, output ready);
endinterface

[src/csta_ram.sv]
// ----------------------------------------------------------------------------
// Client session table RAM
// Simple dual-port RAM, one write and one registered read port with enable.
// ----------------------------------------------------------------------------
module csta_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/client_session_table_with_aging.sv]
// ----------------------------------------------------------------------------
// Client session table with idle aging
// Table of remote clients keyed by address and port, with timeout sweep.
// ----------------------------------------------------------------------------
// All entries live in one RAM with a single read port, and a small sequencer
// walks it one slot per cycle, but a removal stalls the walk to refill the slot
// and may wait for the output register. A packet scans from slot 0 until its
// match or the end of the table; a tick checks every live entry for expiry.
// The block takes no new request until the last result of the current one is
// in the output register; results are held there until the sink takes them.
`include "client_session_table_with_aging_defines.svh"

module client_session_table_with_aging #(
	parameter int unsigned TABLE_DEPTH = csta_pkg::TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [csta_pkg::PADDR_W-1:0]   paddr,
	input  logic [csta_pkg::PDATA_W-1:0]   pwdata,
	output logic [csta_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	csta_req_if.sink                       req,
	csta_rsp_if.source                     rsp
);
	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW    = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_PKT,
		S_AGE,
		S_MOVE,
		S_FINISH
	} state_t;

	state_t                         state_q;
	logic [IDX_W-1:0]               idx_q;
	logic [CW-1:0]                  count_q;
	logic [csta_pkg::TICK_W-1:0]    tick_q;
	logic [csta_pkg::TMO_W-1:0]     timeout_q;
	logic                           hit_q;
	logic [csta_pkg::ADDR_W-1:0]    req_addr_q;
	logic [csta_pkg::PORT_W-1:0]    req_port_q;
	logic [csta_pkg::TICK_W-1:0]    req_ctick_q;

	// one removal held back until we know whether it is the last
	logic                           pend_valid_q;
	logic [IDX_W-1:0]               pend_slot_q;
	logic [csta_pkg::ID_W-1:0]      pend_id_q;
	logic [CW-1:0]                  pend_live_q;

	logic                           ovalid_q;
	csta_pkg::status_t              ostatus_q;
	logic [csta_pkg::SLOT_W-1:0]    oslot_q;
	logic [csta_pkg::ID_W-1:0]      oid_q;
	logic [csta_pkg::LIVE_W-1:0]    olive_q;
	logic [csta_pkg::TICK_W-1:0]    otick_q;
	logic                           olast_q;

	logic                           ram_we;
	logic [IDX_W-1:0]               ram_waddr;
	csta_pkg::entry_t               ram_wdata;
	logic                           ram_re;
	logic [IDX_W-1:0]               ram_raddr;
	logic [csta_pkg::ENTRY_W-1:0]   ram_rdata;
	csta_pkg::entry_t               rd;

	logic                           can_emit;
	logic                           out_load;
	logic                           match;
	logic                           expired;
	logic [csta_pkg::TICK_W-1:0]    age;
	logic [CW-1:0]                  idx_inc;
	logic                           more;
	logic                           not_full;
	logic                           cfg_wr;
	logic [csta_pkg::PADDR_W-3:0]   reg_idx;

	csta_ram #(
		.WIDTH (csta_pkg::ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd       = csta_pkg::entry_t'(ram_rdata);
	assign can_emit = !ovalid_q || rsp.ready;
	assign match    = (rd.address == req_addr_q) && (rd.port == req_port_q);
	assign age      = tick_q - rd.seen_tick;
	assign expired  = age > csta_pkg::TICK_W'(timeout_q);
	assign idx_inc  = CW'(idx_q) + CW'(1);
	assign more     = idx_inc < count_q;
	assign not_full = count_q < CW'(TABLE_DEPTH);

	// load the output register with a new transfer
	assign out_load = can_emit && ((state_q == S_PKT) || (state_q == S_FINISH) ||
		(state_q == S_AGE && expired && pend_valid_q));

	assign reg_idx = paddr[csta_pkg::PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == csta_pkg::REG_IDLE_TIMEOUT) ?
		csta_pkg::PDATA_W'(timeout_q) : '0;

	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid       = ovalid_q;
	assign rsp.status      = ostatus_q;
	assign rsp.slot_index  = oslot_q;
	assign rsp.client_id   = oid_q;
	assign rsp.live_count  = olive_q;
	assign rsp.server_tick = otick_q;
	assign rsp.last_of_run = olast_q;

	// RAM port control
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = rd;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					ram_re    = 1'b1;
					ram_raddr = '0;
				end
			end
			S_LOOK: begin
				if (!match && more) begin
					ram_re    = 1'b1;
					ram_raddr = IDX_W'(idx_inc);
				end
			end
			S_AGE: begin
				if (expired) begin
					if (!pend_valid_q || can_emit) begin
						ram_re    = 1'b1;
						ram_raddr = IDX_W'(count_q - CW'(1));
					end
				end else if (more) begin
					ram_re    = 1'b1;
					ram_raddr = IDX_W'(idx_inc);
				end
			end
			S_MOVE: begin
				// fill the gap with the last live entry
				ram_we = 1'b1;
			end
			S_PKT: begin
				if (can_emit) begin
					if (hit_q) begin
						ram_we    = 1'b1;
						ram_wdata = '{address: rd.address, port: rd.port, id: rd.id,
							seen_tick: tick_q, client_tick: req_ctick_q};
					end else if (not_full) begin
						ram_we    = 1'b1;
						ram_waddr = IDX_W'(count_q);
						ram_wdata = '{address: req_addr_q, port: req_port_q,
							id: csta_pkg::ID_W'(count_q), seen_tick: tick_q,
							client_tick: req_ctick_q};
					end
				end
			end
			default: begin
			end
		endcase
	end

	// payload captures
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			req_addr_q  <= req.source_address;
			req_port_q  <= req.source_port;
			req_ctick_q <= req.client_tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			count_q      <= '0;
			tick_q       <= csta_pkg::TICK_RESET;
			timeout_q    <= csta_pkg::TIMEOUT_RESET;
			hit_q        <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_slot_q  <= '0;
			pend_id_q    <= '0;
			pend_live_q  <= '0;
			ovalid_q     <= 1'b0;
			ostatus_q    <= csta_pkg::ST_HIT;
			oslot_q      <= '0;
			oid_q        <= '0;
			olive_q      <= '0;
			otick_q      <= '0;
			olast_q      <= 1'b0;
		end else begin
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			if (cfg_wr && reg_idx == csta_pkg::REG_IDLE_TIMEOUT) begin
				timeout_q <= pwdata[csta_pkg::TMO_W-1:0];
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						idx_q <= '0;
						hit_q <= 1'b0;
						if (req.req_type) begin
							state_q <= (count_q == '0) ? S_FINISH : S_AGE;
						end else begin
							state_q <= (count_q == '0) ? S_PKT : S_LOOK;
						end
					end
				end
				S_LOOK: begin
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= S_PKT;
					end else if (more) begin
						idx_q <= IDX_W'(idx_inc);
					end else begin
						state_q <= S_PKT;
					end
				end
				S_PKT: begin
					if (can_emit) begin
						otick_q  <= tick_q;
						olast_q  <= 1'b1;
						if (hit_q) begin
							ostatus_q <= csta_pkg::ST_HIT;
							oslot_q   <= csta_pkg::SLOT_W'(idx_q);
							oid_q     <= rd.id;
							olive_q   <= csta_pkg::LIVE_W'(count_q);
						end else if (not_full) begin
							ostatus_q <= csta_pkg::ST_NEW;
							oslot_q   <= csta_pkg::SLOT_W'(count_q);
							oid_q     <= csta_pkg::ID_W'(count_q);
							olive_q   <= csta_pkg::LIVE_W'(count_q + CW'(1));
							count_q   <= count_q + CW'(1);
						end else begin
							ostatus_q <= csta_pkg::ST_FULL;
							oslot_q   <= '0;
							oid_q     <= '0;
							olive_q   <= csta_pkg::LIVE_W'(count_q);
						end
						state_q <= S_IDLE;
					end
				end
				S_AGE: begin
					if (expired) begin
						if (!pend_valid_q || can_emit) begin
							// release the previous removal, it is not the last
							if (pend_valid_q) begin
								ostatus_q <= csta_pkg::ST_TIMED_OUT;
								oslot_q   <= csta_pkg::SLOT_W'(pend_slot_q);
								oid_q     <= pend_id_q;
								olive_q   <= csta_pkg::LIVE_W'(pend_live_q);
								otick_q   <= tick_q;
								olast_q   <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_slot_q  <= idx_q;
							pend_id_q    <= rd.id;
							pend_live_q  <= count_q - CW'(1);
							count_q      <= count_q - CW'(1);
							state_q      <= S_MOVE;
						end
					end else if (more) begin
						idx_q <= IDX_W'(idx_inc);
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_MOVE: begin
					// read data still holds the moved entry: check it again
					state_q <= (CW'(idx_q) < count_q) ? S_AGE : S_FINISH;
				end
				S_FINISH: begin
					if (can_emit) begin
						otick_q  <= tick_q;
						olast_q  <= 1'b1;
						if (pend_valid_q) begin
							ostatus_q <= csta_pkg::ST_TIMED_OUT;
							oslot_q   <= csta_pkg::SLOT_W'(pend_slot_q);
							oid_q     <= pend_id_q;
							olive_q   <= csta_pkg::LIVE_W'(pend_live_q);
						end else begin
							ostatus_q <= csta_pkg::ST_SWEEP_NONE;
							oslot_q   <= '0;
							oid_q     <= '0;
							olive_q   <= csta_pkg::LIVE_W'(count_q);
						end
						pend_valid_q <= 1'b0;
						tick_q       <= tick_q + csta_pkg::TICK_W'(1);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`CSTA_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(TABLE_DEPTH), "live count exceeds table depth")
	`CSTA_ASSERT_IMP(a_idle_no_pend, clk, arst_n, state_q == S_IDLE, !pend_valid_q, "removal left pending at idle")
	`CSTA_ASSERT_NXT(a_tick_adv, clk, arst_n, state_q == S_FINISH && can_emit, tick_q == $past(tick_q) + csta_pkg::TICK_W'(1), "server tick did not advance after sweep")
	`CSTA_ASSERT_IMP(a_move_slot, clk, arst_n, state_q == S_MOVE, CW'(idx_q) <= count_q && pend_valid_q, "gap fill outside live range")

endmodule

[tb/client_session_table_with_aging_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Client session table testbench
// Drives packet and tick requests with bursty timing against a stalling
// result sink. Each accepted request runs through a local table model, and
// every result transfer is compared with the oldest predicted result.
// ----------------------------------------------------------------------------
module client_session_table_with_aging_tb;

	localparam int unsigned DEPTH = csta_pkg::TABLE_DEPTH_DEF;
	localparam logic [csta_pkg::PADDR_W-3:0] REG_UNUSED = 1'b1;
	localparam logic REQ_PACKET = 1'b0;
	localparam logic REQ_TICK = 1'b1;
	localparam int unsigned SHOW_LIMIT = 10;
	localparam int unsigned NUM_PHASES = 6;
	localparam int unsigned NUM_KEYS = 96;

	typedef enum int unsigned {
		SINK_FREE,
		SINK_COIN,
		SINK_PERIODIC,
		SINK_BURSTY
	} sink_mode_t;

	typedef struct packed {
		csta_pkg::status_t           status;
		logic [csta_pkg::SLOT_W-1:0] slot_index;
		logic [csta_pkg::ID_W-1:0]   client_id;
		logic [csta_pkg::LIVE_W-1:0] live_count;
		logic [csta_pkg::TICK_W-1:0] server_tick;
		logic                        last_of_run;
	} session_result_t;

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [csta_pkg::PADDR_W-1:0] paddr;
	logic [csta_pkg::PDATA_W-1:0] pwdata;
	logic [csta_pkg::PDATA_W-1:0] prdata;
	logic                         pready;

	csta_req_if req_ch();
	csta_rsp_if rsp_ch();

	client_session_table_with_aging dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	// session table model
	logic [csta_pkg::ADDR_W-1:0] tbl_address     [DEPTH];
	logic [csta_pkg::PORT_W-1:0] tbl_port        [DEPTH];
	logic [csta_pkg::ID_W-1:0]   tbl_id          [DEPTH];
	logic [csta_pkg::TICK_W-1:0] tbl_seen        [DEPTH];
	logic [csta_pkg::TICK_W-1:0] tbl_client_tick [DEPTH];
	int unsigned                 live_entries = 0;
	logic [csta_pkg::TICK_W-1:0] server_now = csta_pkg::TICK_RESET;
	logic [csta_pkg::TMO_W-1:0]  idle_limit = csta_pkg::TIMEOUT_RESET;

	session_result_t pending_results[$];
	int unsigned     mismatch_count = 0;
	int unsigned     burst_left = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic void note_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= SHOW_LIMIT)
			$display("%0t mismatch: %s", $time, msg);
	endfunction

	function automatic string describe_result(session_result_t r);
		return $sformatf("status=%0d slot=%0d id=%0d live=%0d tick=%0d last=%0b",
			r.status, r.slot_index, r.client_id, r.live_count, r.server_tick, r.last_of_run);
	endfunction

	function automatic session_result_t make_result(csta_pkg::status_t st, int unsigned slot,
			int unsigned id, int unsigned live, logic [csta_pkg::TICK_W-1:0] tick, logic last);
		session_result_t r;
		r.status      = st;
		r.slot_index  = csta_pkg::SLOT_W'(slot);
		r.client_id   = csta_pkg::ID_W'(id);
		r.live_count  = csta_pkg::LIVE_W'(live);
		r.server_tick = tick;
		r.last_of_run = last;
		return r;
	endfunction

	function automatic void predict_session_results(logic kind,
			logic [csta_pkg::ADDR_W-1:0] addr, logic [csta_pkg::PORT_W-1:0] port,
			logic [csta_pkg::TICK_W-1:0] ctick);
		int unsigned                 slot;
		int unsigned                 removed;
		int unsigned                 tail;
		logic [csta_pkg::TICK_W-1:0] now;
		logic [csta_pkg::TICK_W-1:0] age;
		session_result_t             r;
		if (kind == REQ_PACKET) begin
			slot = 0;
			while (slot < live_entries && !(tbl_address[slot] == addr && tbl_port[slot] == port))
				slot++;
			if (slot < live_entries) begin
				tbl_client_tick[slot] = ctick;
				tbl_seen[slot] = server_now;
				pending_results.push_back(make_result(csta_pkg::ST_HIT, slot, tbl_id[slot],
					live_entries, server_now, 1'b1));
			end else if (live_entries < DEPTH) begin
				tbl_address[slot] = addr;
				tbl_port[slot] = port;
				tbl_id[slot] = csta_pkg::ID_W'(slot);
				tbl_client_tick[slot] = ctick;
				tbl_seen[slot] = server_now;
				live_entries++;
				pending_results.push_back(make_result(csta_pkg::ST_NEW, slot, slot,
					live_entries, server_now, 1'b1));
			end else begin
				pending_results.push_back(make_result(csta_pkg::ST_FULL, 0, 0, live_entries,
					server_now, 1'b1));
			end
		end else begin
			now = server_now;
			removed = 0;
			slot = 0;
			while (slot < live_entries) begin
				age = now - tbl_seen[slot];
				if (age > idle_limit) begin
					tail = live_entries - 1;
					pending_results.push_back(make_result(csta_pkg::ST_TIMED_OUT, slot,
						tbl_id[slot], tail, now, 1'b0));
					// fill the gap from the tail; the slot is checked again
					tbl_address[slot] = tbl_address[tail];
					tbl_port[slot] = tbl_port[tail];
					tbl_id[slot] = tbl_id[tail];
					tbl_seen[slot] = tbl_seen[tail];
					tbl_client_tick[slot] = tbl_client_tick[tail];
					live_entries = tail;
					removed++;
				end else begin
					slot++;
				end
			end
			if (removed == 0) begin
				pending_results.push_back(make_result(csta_pkg::ST_SWEEP_NONE, 0, 0,
					live_entries, now, 1'b1));
			end else begin
				r = pending_results.pop_back();
				r.last_of_run = 1'b1;
				pending_results.push_back(r);
			end
			server_now = now + 1;
		end
	endfunction

	task automatic send_request(input logic kind, input logic [csta_pkg::ADDR_W-1:0] addr,
			input logic [csta_pkg::PORT_W-1:0] port, input logic [csta_pkg::TICK_W-1:0] ctick);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			gap = $urandom_range(0, 12);
			if (gap != 0) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.source_address <= addr;
		req_ch.source_port <= port;
		req_ch.client_tick <= ctick;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predict_session_results(kind, addr, port, ctick);
	endtask

	task automatic send_tick();
		send_request(REQ_TICK, $urandom, csta_pkg::PORT_W'($urandom_range(0, 65535)), $urandom);
	endtask

	// drop valid and let every predicted result drain out
	task automatic wait_idle(input int unsigned settle);
		int unsigned guard;
		@(negedge clk);
		req_ch.valid <= 1'b0;
		burst_left = 0;
		guard = 0;
		while (pending_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [csta_pkg::PADDR_W-3:0] index,
			input logic [csta_pkg::PDATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (index == csta_pkg::REG_IDLE_TIMEOUT)
			idle_limit = value[csta_pkg::TMO_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_timeout_readback();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {csta_pkg::REG_IDLE_TIMEOUT, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata[csta_pkg::TMO_W-1:0] !== idle_limit)
			note_mismatch($sformatf("timeout readback expected %0d got %0d", idle_limit,
				prdata[csta_pkg::TMO_W-1:0]));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_register_access();
		check_timeout_readback();
		// upper half of the write data is dropped
		write_timeout(csta_pkg::REG_IDLE_TIMEOUT, 32'h5A5A_0007);
		check_timeout_readback();
		write_timeout(REG_UNUSED, 32'hA5A5_FFFF);
		check_timeout_readback();
		write_timeout(csta_pkg::REG_IDLE_TIMEOUT, {16'hFFFF, csta_pkg::TIMEOUT_RESET});
		check_timeout_readback();
	endtask

	task automatic test_directed_cases();
		send_tick();
		send_request(REQ_PACKET, 32'h0000_0000, 16'h0000, 32'h8000_0000);
		send_request(REQ_PACKET, 32'hFFFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF);
		send_request(REQ_PACKET, 32'h0000_0000, 16'hFFFF, 32'h0000_0000);
		send_request(REQ_PACKET, 32'hFFFF_FFFF, 16'h0000, 32'hFFFF_FFFF);
		send_request(REQ_PACKET, 32'h0000_0000, 16'h0000, 32'hFFFF_FFFF);
		send_request(REQ_PACKET, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000);
		send_request(REQ_PACKET, 32'hAAAA_AAAA, 16'h5555, 32'h5555_5555);
		send_request(REQ_PACKET, 32'h5555_5555, 16'hAAAA, 32'hAAAA_AAAA);
		send_tick();
		wait_idle(16);

		// zero timeout: refresh one entry, then age the rest out with refills
		write_timeout(csta_pkg::REG_IDLE_TIMEOUT, 32'hFFFF_0000);
		send_request(REQ_PACKET, 32'h0000_0000, 16'hFFFF, 32'h1234_5678);
		send_tick();
		send_tick();
		send_tick();
		wait_idle(16);

		// an entry survives at age equal to the timeout and goes one tick later
		write_timeout(csta_pkg::REG_IDLE_TIMEOUT, 32'h0000_0001);
		send_request(REQ_PACKET, 32'h1234_5678, 16'h1234, 32'h0000_0001);
		send_tick();
		send_tick();
		send_tick();
		wait_idle(16);

		write_timeout(csta_pkg::REG_IDLE_TIMEOUT, 32'h0000_FFFF);
		send_request(REQ_PACKET, 32'hC0A8_0001, 16'd27015, 32'hFFFF_FFFE);
		send_tick();
		send_tick();
		wait_idle(16);
	endtask

	task automatic test_table_overflow();
		while (live_entries < DEPTH)
			send_request(REQ_PACKET, $urandom,
				{10'($urandom), csta_pkg::ID_W'(live_entries)}, $urandom);
		repeat (3) send_request(REQ_PACKET, $urandom,
			csta_pkg::PORT_W'($urandom_range(0, 65535)), $urandom);
		send_request(REQ_PACKET, tbl_address[DEPTH-1], tbl_port[DEPTH-1], $urandom);
		send_tick();
		wait_idle(16);
		// every entry is now idle for at least one tick: clear the whole table
		write_timeout(csta_pkg::REG_IDLE_TIMEOUT, {16'($urandom), 16'd0});
		check_timeout_readback();
		send_tick();
		send_tick();
		wait_idle(16);
	endtask

	task automatic test_random_traffic();
		logic [csta_pkg::ADDR_W-1:0] key_addr [NUM_KEYS];
		logic [csta_pkg::PORT_W-1:0] key_port [NUM_KEYS];
		logic [csta_pkg::TMO_W-1:0]  phase_limit [NUM_PHASES];
		int unsigned                 tick_weight [NUM_PHASES];
		int unsigned                 key_span [NUM_PHASES];
		int unsigned                 pick;
		int unsigned                 roll;
		phase_limit = '{16'd2, 16'd0, 16'd65535, 16'd6, 16'd1, 16'd300};
		tick_weight = '{25, 35, 10, 20, 30, 15};
		key_span = '{16, 40, 96, 24, 12, 96};
		// neighbors often share the address or the port
		for (int k = 0; k < NUM_KEYS; k++) begin
			roll = $urandom_range(0, 3);
			key_addr[k] = (k > 0 && roll == 0) ? key_addr[k-1] : $urandom;
			key_port[k] = (k > 0 && roll == 1) ? key_port[k-1]
				: csta_pkg::PORT_W'($urandom_range(0, 65535));
		end
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle(16);
			write_timeout(csta_pkg::REG_IDLE_TIMEOUT, {16'($urandom), phase_limit[ph]});
			if (ph == 3)
				write_timeout(REG_UNUSED, $urandom);
			check_timeout_readback();
			for (int n = 0; n < 45; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < tick_weight[ph]) begin
					send_tick();
				end else if (roll < tick_weight[ph] + 8) begin
					send_request(REQ_PACKET, $urandom,
						csta_pkg::PORT_W'($urandom_range(0, 65535)), $urandom);
				end else begin
					pick = $urandom_range(0, key_span[ph] - 1);
					send_request(REQ_PACKET, key_addr[pick], key_port[pick], $urandom);
				end
			end
		end
	endtask

	// result sink: switches at random between four stall patterns
	initial begin
		sink_mode_t  mode;
		int unsigned mode_left;
		int unsigned stall_left;
		int unsigned phase;
		rsp_ch.ready = 1'b0;
		mode = SINK_FREE;
		mode_left = 0;
		stall_left = 0;
		phase = 0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			phase++;
			case (mode)
				SINK_FREE: begin
					rsp_ch.ready <= 1'b1;
				end
				SINK_COIN: begin
					rsp_ch.ready <= 1'($urandom_range(0, 1));
				end
				SINK_PERIODIC: begin
					rsp_ch.ready <= (phase % 7) >= 3;
				end
				default: begin
					if (stall_left != 0) begin
						stall_left--;
						rsp_ch.ready <= 1'b0;
					end else begin
						rsp_ch.ready <= 1'b1;
						if ($urandom_range(0, 5) == 0)
							stall_left = $urandom_range(4, 20);
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		session_result_t seen;
		session_result_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			seen.status = csta_pkg::status_t'(rsp_ch.status);
			seen.slot_index = rsp_ch.slot_index;
			seen.client_id = rsp_ch.client_id;
			seen.live_count = rsp_ch.live_count;
			seen.server_tick = rsp_ch.server_tick;
			seen.last_of_run = rsp_ch.last_of_run;
			if (pending_results.size() == 0) begin
				note_mismatch({"result with none expected: ", describe_result(seen)});
			end else begin
				want = pending_results.pop_front();
				if (seen !== want)
					note_mismatch({"expected ", describe_result(want), " got ",
						describe_result(seen)});
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_PACKET;
		req_ch.source_address = '0;
		req_ch.source_port = '0;
		req_ch.client_tick = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_access();
		test_directed_cases();
		test_table_overflow();
		test_random_traffic();

		wait_idle(200);
		if (pending_results.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
